FILE: hdl/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/kahpq_pkg.sv
// Shared types, constants and key ordering for the K-ary heap priority queue.
// No dependencies; imported by the sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package kahpq_pkg;

  localparam int KEY_W   = 32;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_NONE = -32'sd1;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REPLACE = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAPTURE,
    S_UP_RD,
    S_UP_CMP,
    S_DROP,
    S_LAST,
    S_SK_START,
    S_SK_CMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t               op;
    key_t              key;
    logic [IDX_W-1:0]  idx;
  } req_t;

  typedef struct packed {
    status_t            status;
    key_t               top_key;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // true when key b belongs above key a under the current order
  function automatic logic ranks_above(input key_t a, input key_t b,
                                       input logic smallest_first);
    return smallest_first ? (b < a) : (b > a);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/kahpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kahpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kahpq_seq.sv
// Operation sequencer: walks the heap in the key RAM, at most one access per cycle.
// Depends on kahpq_pkg; drives the ports of one kahpq_ram instance.
`timescale 1ns / 1ps
`default_nettype none

module kahpq_seq
  import kahpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int ARITY    = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        smallest_first,
  input  wire logic                        start,
  input  wire req_t                        req,
  output logic                             ready,
  output logic                             done_valid,
  input  wire logic                        done_ready,
  output rsp_t                             rsp,
  output logic                             mem_we,
  output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
  output key_t                             mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
  input  wire key_t                        mem_rdata
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int CHW = $clog2(ARITY * CAPACITY + 1);
  localparam int JW  = $clog2(ARITY + 1);
  // parent = (pos - 1) / ARITY as multiply by reciprocal, exact below 2**AW
  localparam int PS   = AW + $clog2(ARITY);
  localparam int PW   = AW + PS + 1;
  localparam int PMUL = ((1 << PS) + ARITY - 1) / ARITY;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   par_r, par_nxt;
  logic [AW-1:0]   best_r, best_nxt;
  key_t            cur_r, cur_nxt;
  key_t            bestkey_r, bestkey_nxt;
  key_t            top_r, top_nxt;
  status_t         status_r, status_nxt;
  logic            del_r, del_nxt;
  logic [CHW-1:0]  child_r, child_nxt;
  logic [JW-1:0]   j_r, j_nxt;

  logic [PW-1:0]   par_prod;
  logic [AW-1:0]   parent;
  logic [CHW-1:0]  child_first;
  logic [CHW-1:0]  child_next;
  logic            take;
  logic            last_child;
  logic [AW-1:0]   nb;
  key_t            nbk;

  assign par_prod    = PW'(pos_r - AW'(1)) * PW'(PMUL);
  assign parent      = par_prod[PS +: AW];
  assign child_first = CHW'(pos_r) * CHW'(ARITY) + CHW'(1);
  assign child_next  = child_r + CHW'(1);
  assign take        = ranks_above(bestkey_r, mem_rdata, smallest_first);
  assign last_child  = (j_r == JW'(ARITY)) || (child_next >= CHW'(count_r));
  assign nb          = take ? AW'(child_r) : best_r;
  assign nbk         = take ? mem_rdata : bestkey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    par_r     <= par_nxt;
    best_r    <= best_nxt;
    cur_r     <= cur_nxt;
    bestkey_r <= bestkey_nxt;
    top_r     <= top_nxt;
    status_r  <= status_nxt;
    del_r     <= del_nxt;
    child_r   <= child_nxt;
    j_r       <= j_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    par_nxt     = par_r;
    best_nxt    = best_r;
    cur_nxt     = cur_r;
    bestkey_nxt = bestkey_r;
    top_nxt     = top_r;
    status_nxt  = status_r;
    del_nxt     = del_r;
    child_nxt   = child_r;
    j_nxt       = j_r;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = cur_r;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    ready       = 1'b0;
    done_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          status_nxt = STAT_OK;
          top_nxt    = '0;
          del_nxt    = 1'b0;
          cur_nxt    = req.key;
          unique case (req.op)
            OP_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_FINISH;
              end else begin
                pos_nxt   = AW'(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            OP_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
                top_nxt    = KEY_NONE;
                state_nxt  = S_FINISH;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_nxt = S_CAPTURE;
              end
            end
            OP_REPLACE, OP_DELETE: begin
              if (XW'(req.idx) >= XW'(count_r)) begin
                status_nxt = STAT_BAD_INDEX;
                state_nxt  = S_FINISH;
              end else if (req.op == OP_REPLACE) begin
                pos_nxt   = AW'(req.idx);
                state_nxt = S_UP_RD;
              end else begin
                pos_nxt   = AW'(req.idx);
                del_nxt   = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = AW'(req.idx);
                state_nxt = S_CAPTURE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_CAPTURE: begin
        top_nxt   = mem_rdata;
        state_nxt = del_r ? S_UP_RD : S_DROP;
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          if (del_r) begin
            state_nxt = S_DROP;
          end else begin
            mem_we    = 1'b1;
            state_nxt = S_FINISH;
          end
        end else begin
          par_nxt   = parent;
          mem_re    = 1'b1;
          mem_raddr = parent;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        // a delete pulls every ancestor down one level unconditionally
        if (del_r || ranks_above(mem_rdata, cur_r, smallest_first)) begin
          mem_wdata = mem_rdata;
          pos_nxt   = par_r;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_DROP: begin
        count_nxt = count_r - CW'(1);
        if (count_r == CW'(1)) begin
          state_nxt = S_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(count_r - CW'(1));
          state_nxt = S_LAST;
        end
      end

      S_LAST: begin
        cur_nxt   = mem_rdata;
        pos_nxt   = '0;
        state_nxt = S_SK_START;
      end

      S_SK_START: begin
        best_nxt    = pos_r;
        bestkey_nxt = cur_r;
        child_nxt   = child_first;
        j_nxt       = JW'(1);
        if (child_first >= CHW'(count_r)) begin
          mem_we    = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(child_first);
          state_nxt = S_SK_CMP;
        end
      end

      S_SK_CMP: begin
        best_nxt    = nb;
        bestkey_nxt = nbk;
        if (!last_child) begin
          child_nxt = child_next;
          j_nxt     = j_r + JW'(1);
          mem_re    = 1'b1;
          mem_raddr = AW'(child_next);
        end else if (nb == pos_r) begin
          mem_we    = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          // move the best child up into the hole and follow it
          mem_we    = 1'b1;
          mem_wdata = nbk;
          pos_nxt   = nb;
          state_nxt = S_SK_START;
        end
      end

      S_FINISH: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign rsp.status  = status_r;
  assign rsp.top_key = top_r;
  assign rsp.count   = COUNT_W'(count_r);

endmodule

`default_nettype wire

FILE: hdl/k_ary_heap_priority_queue_top.sv
// K-ary heap priority queue of signed 32-bit keys, one operation per input
// word (insert, extract top, replace key at index, delete at index) and one
// result word per operation. Keys live in a single synchronous RAM of CAPACITY
// entries; each heap step makes at most one RAM access per cycle. Full, empty
// and bad-index cases go straight to the result without touching the RAM. The
// single read port means each child of a node is read in its own cycle. For 64
// keys in a binary heap the worst operation is a delete of the deepest entry: a
// climb of 6 levels and a sink of 5 levels. A finished result sits in the
// output register so the next word can be taken while it waits. The user
// must write smallest_first only while idle; the block does not enforce it.
// Depends on kahpq_pkg, kahpq_seq, kahpq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module k_ary_heap_priority_queue_top
  import kahpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int ARITY    = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data,     // [0] smallest_first
  // operation words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,     // [31:0] key, [37:32] index, [39:38] zero
  input  wire logic [1:0]  in_tuser,     // [1:0] operation
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,    // [31:0] top_key, [38:32] count, [39] zero
  output logic [1:0]       out_tuser     // [1:0] status
);

  localparam int AW = $clog2(CAPACITY);

  logic           sf_r;
  logic           out_valid_r;
  rsp_t           out_rsp_r;

  req_t           req;
  rsp_t           rsp;
  logic           seq_ready;
  logic           done_valid;
  logic           done_ready;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  key_t           mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  key_t           mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= 1'b0;
    end else if (cfg_valid) begin
      sf_r <= cfg_data[0];
    end
  end

  assign req.op  = op_t'(in_tuser);
  assign req.key = key_t'(in_tdata[KEY_W-1:0]);
  assign req.idx = in_tdata[KEY_W +: IDX_W];

  assign in_tready  = seq_ready;
  assign done_ready = !out_valid_r || out_tready;

  kahpq_seq #(
    .CAPACITY (CAPACITY),
    .ARITY    (ARITY)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .smallest_first (sf_r),
    .start          (in_tvalid && seq_ready),
    .req            (req),
    .ready          (seq_ready),
    .done_valid     (done_valid),
    .done_ready     (done_ready),
    .rsp            (rsp),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  kahpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_rsp_r.count, out_rsp_r.top_key};
  assign out_tuser  = out_rsp_r.status;

  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready,
              "input taken while an operation is in flight")
  `ASSERT_IMP(a_full_count, clk, rst_n,
              out_valid_r && (out_rsp_r.status == STAT_FULL),
              out_rsp_r.count == COUNT_W'(CAPACITY),
              "full reported below capacity")
  `ASSERT_IMP(a_empty_result, clk, rst_n,
              out_valid_r && (out_rsp_r.status == STAT_EMPTY),
              (out_rsp_r.count == '0) && (out_rsp_r.top_key == KEY_NONE),
              "empty reported with keys held or wrong key")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking bench for k_ary_heap_priority_queue_top: a heap model kept in step
// with every accepted operation word is checked against each result word.
// Depends on kahpq_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb
  import kahpq_pkg::*;
();

  localparam int CAPACITY = 64;
  localparam int ARITY    = 2;
  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  k_ary_heap_priority_queue_top #(
    .CAPACITY(CAPACITY),
    .ARITY   (ARITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // heap model state
  key_t        heap_keys [CAPACITY];
  int unsigned heap_count = 0;
  logic        order_min  = 1'b0;

  req_t        pending_ops [$];
  rsp_t        expected_results [$];
  req_t        drv_word;
  int unsigned gen_count    = 0;
  int unsigned queued_ops   = 0;
  int unsigned accepted_ops = 0;
  int unsigned checked_results = 0;
  int unsigned mismatch_count  = 0;
  int unsigned op_seen [4]     = '{0, 0, 0, 0};
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // true when key b belongs above key a under the current order
  function automatic bit beats(key_t a, key_t b);
    return order_min ? (b < a) : (b > a);
  endfunction

  function automatic void swap_keys(int unsigned x, int unsigned y);
    key_t t;
    t = heap_keys[x];
    heap_keys[x] = heap_keys[y];
    heap_keys[y] = t;
  endfunction

  function automatic void sift_up(int unsigned pos, bit to_root);
    int unsigned up;
    while (pos != 0) begin
      up = (pos - 1) / ARITY;
      if (!to_root && !beats(heap_keys[up], heap_keys[pos])) break;
      swap_keys(pos, up);
      pos = up;
    end
  endfunction

  function automatic void sift_down(int unsigned pos);
    int unsigned best;
    int unsigned c;
    while (pos < heap_count) begin
      best = pos;
      for (int j = 1; j <= ARITY; j++) begin
        c = ARITY * pos + j;
        if (c < heap_count && beats(heap_keys[best], heap_keys[c])) best = c;
      end
      if (best == pos) break;
      swap_keys(pos, best);
      pos = best;
    end
  endfunction

  function automatic key_t pop_top();
    key_t top;
    top = heap_keys[0];
    heap_count--;
    if (heap_count > 0) begin
      heap_keys[0] = heap_keys[heap_count];
      sift_down(0);
    end
    return top;
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t res;
    res.status  = STAT_OK;
    res.top_key = '0;
    case (r.op)
      OP_INSERT: begin
        if (heap_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          heap_keys[heap_count] = r.key;
          heap_count++;
          sift_up(heap_count - 1, 1'b0);
        end
      end
      OP_EXTRACT: begin
        if (heap_count == 0) begin
          res.status  = STAT_EMPTY;
          res.top_key = KEY_NONE;
        end else begin
          res.top_key = pop_top();
        end
      end
      default: begin
        if (r.idx >= heap_count) begin
          res.status = STAT_BAD_INDEX;
        end else if (r.op == OP_REPLACE) begin
          heap_keys[r.idx] = r.key;
          sift_up(r.idx, 1'b0);
        end else begin
          // delete: float the entry to the root regardless of order, then pop it
          res.top_key = heap_keys[r.idx];
          sift_up(r.idx, 1'b1);
          void'(pop_top());
        end
      end
    endcase
    res.count = heap_count[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // driver: present one word at a time, advance on handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accepted_ops++;
        op_seen[drv_word.op]++;
        expected_results = {expected_results, heap_apply(drv_word)};
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_word = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, drv_word.idx, drv_word.key};
          in_tuser  <= drv_word.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: tuser %0d tdata %h",
                                    out_tuser, out_tdata));
        end else begin
          want = expected_results.pop_front();
          checked_results++;
          status_seen[want.status]++;
          if (out_tuser !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
          if (out_tdata[31:0] !== want.top_key)
            report_mismatch($sformatf("top_key %0d, want %0d",
                                      $signed(out_tdata[31:0]), want.top_key));
          if (out_tdata[38:32] !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", out_tdata[38:32], want.count));
          if (out_tdata[39] !== 1'b0)
            report_mismatch("padding bit of result word is not zero");
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_op(input op_t op, input key_t key, input int unsigned idx);
    req_t r;
    r.op  = op;
    r.key = key;
    r.idx = idx[IDX_W-1:0];
    pending_ops = {pending_ops, r};
    queued_ops++;
    case (op)
      OP_INSERT:  if (gen_count < CAPACITY) gen_count++;
      OP_EXTRACT: if (gen_count > 0) gen_count--;
      OP_DELETE:  if (r.idx < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return '0;
          default: return KEY_NONE;
        endcase
      end
      // narrow range to force ties
      1, 2: return key_t'($urandom_range(16)) - 8;
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic rand_op();
    op_t         op;
    int unsigned idx;
    op = op_t'($urandom_range(3));
    if (gen_count > 0 && $urandom_range(99) < 80) idx = $urandom_range(gen_count - 1);
    else idx = $urandom_range(63);
    add_op(op, pick_key(), idx);
  endtask

  // some fill-to-full and drain-to-empty runs, mostly mixed traffic
  task automatic gen_random(input int unsigned n);
    int unsigned stop_at;
    stop_at = queued_ops + n;
    while (queued_ops < stop_at) begin
      case ($urandom_range(9))
        0, 1: begin
          while (gen_count < CAPACITY) begin
            if ($urandom_range(99) < 85) add_op(OP_INSERT, pick_key(), $urandom_range(63));
            else rand_op();
          end
          repeat ($urandom_range(1, 3)) add_op(OP_INSERT, pick_key(), $urandom_range(63));
        end
        2, 3: begin
          while (gen_count > 0) begin
            if ($urandom_range(99) < 85) add_op(OP_EXTRACT, pick_key(), $urandom_range(63));
            else rand_op();
          end
          repeat ($urandom_range(1, 2)) add_op(OP_EXTRACT, pick_key(), $urandom_range(63));
          add_op(OP_DELETE, pick_key(), $urandom_range(63));
        end
        default: repeat ($urandom_range(20, 60)) rand_op();
      endcase
    end
  endtask

  task automatic wait_drained();
    while (accepted_ops != queued_ops || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(input logic smallest);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= smallest;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_min = smallest;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 65;
    write_order(1'b0);
    add_op(OP_EXTRACT, '0, 0);
    add_op(OP_DELETE, '0, 0);
    add_op(OP_REPLACE, KEY_MAX, 63);
    add_op(OP_INSERT, 5, 0);
    add_op(OP_INSERT, 5, 0);
    add_op(OP_INSERT, KEY_MAX, 0);
    add_op(OP_INSERT, KEY_MIN, 0);
    add_op(OP_INSERT, KEY_NONE, 0);
    add_op(OP_INSERT, '0, 0);
    add_op(OP_INSERT, 32'shAAAA_AAAA, 0);
    add_op(OP_REPLACE, KEY_MAX, 6);
    add_op(OP_REPLACE, -100, 3);
    add_op(OP_REPLACE, 1, 7);
    add_op(OP_DELETE, '0, 6);
    add_op(OP_DELETE, '0, 0);
    add_op(OP_DELETE, '0, 42);
    add_op(OP_REPLACE, 32'sh5555_5555, 21);
    add_op(OP_EXTRACT, '0, 0);
    add_op(OP_INSERT, KEY_MAX - 1, 0);
    add_op(OP_DELETE, '0, gen_count - 1);
    while (gen_count > 0) add_op(OP_EXTRACT, '0, 0);
    add_op(OP_EXTRACT, '0, 0);
    wait_drained();

    write_order(1'b1);
    gen_random(400);
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 38;
    write_order(1'b0);
    gen_random(400);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_order(1'b1);
    gen_random(200);
    wait_drained();
    write_order(1'b0);
    gen_random(200);
    wait_drained();

    repeat (40) @(posedge clk);
    $display("Checked %0d results: %0d inserts, %0d extracts, %0d replaces, %0d deletes",
             checked_results, op_seen[OP_INSERT], op_seen[OP_EXTRACT],
             op_seen[OP_REPLACE], op_seen[OP_DELETE]);
    $display("Full %0d, empty %0d, bad index %0d; both key orders, three pacing stages",
             status_seen[STAT_FULL], status_seen[STAT_EMPTY], status_seen[STAT_BAD_INDEX]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still pending", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
